@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ccal_pkg.sv @@
// ----------------------------------------------------------------------------
// ccal_pkg
// types, constants and calendar helper functions for the calendar clock
// ----------------------------------------------------------------------------
`default_nettype none

package ccal_pkg;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_SET_DATE = 2'd1,
        MODE_SET_TIME = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } item_t;

    typedef struct packed {
        cal_t now;
        logic second_elapsed;
    } result_t;

    localparam int TDATA_W  = 48;
    localparam int TUSER_IN_W = 2;
    localparam int TPS_W    = 7;

    localparam logic [TPS_W-1:0] TPS_RESET = 7'd100;

    localparam cal_t CAL_RESET = '{
        year:   16'd2025,
        month:  4'd11,
        day:    5'd14,
        hour:   5'd17,
        minute: 6'd42,
        second: 6'd0
    };

    localparam logic [6:0] SEC_PER_MIN  = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;
    localparam logic [4:0] MONTH_PER_YEAR = 5'd12;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
    localparam logic [4:0] LONG_MONTH_DAYS = 5'd31;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiplicative inverse of 25 modulo 2^16 and the largest quotient
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    // exact divisibility by 25: y * inv(25) mod 2^16 lands in the quotient range
    function automatic logic div_by_25(input logic [15:0] y);
        logic [15:0] p;
        p = y * INV25;
        return (p <= DIV25_MAX);
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        logic d4;
        logic d16;
        logic d25;
        d4  = (y[1:0] == 2'd0);
        d16 = (y[3:0] == 4'd0);
        d25 = div_by_25(y);
        return (d16 && d25) || (d4 && !d25);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == MONTH_FEB && leap)
            return FEB_LEAP_DAYS;
        else if (month >= 4'd1 && month <= MONTH_PER_YEAR[3:0])
            return MONTH_LEN[idx];
        else
            return LONG_MONTH_DAYS;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ccal_in_reg.sv @@
// ----------------------------------------------------------------------------
// ccal_in_reg
// input register stage: unpacks a slave beat and holds it until consumed
// ----------------------------------------------------------------------------
`default_nettype none

module ccal_in_reg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [ccal_pkg::TDATA_W-1:0]       s_tdata,
    input  wire logic [ccal_pkg::TUSER_IN_W-1:0]    s_tuser,
    input  wire logic                               adv,
    output logic                                    item_vld,
    output ccal_pkg::item_t                         item
);
    import ccal_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign s_tready = !vld_reg || adv;
    assign take     = s_tvalid && s_tready;
    assign vld_next = take || (vld_reg && !adv);

    always_comb
    begin
        item_next.mode       = mode_t'(s_tuser[1:0]);
        item_next.set_year   = s_tdata[15:0];
        item_next.set_month  = s_tdata[19:16];
        item_next.set_day    = s_tdata[24:20];
        item_next.set_hour   = s_tdata[29:25];
        item_next.set_minute = s_tdata[35:30];
        item_next.set_second = s_tdata[41:36];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

@@ rtl/ccal_core.sv @@
// ----------------------------------------------------------------------------
// ccal_core
// prescaler and calendar state with the one-second carry cascade
// ----------------------------------------------------------------------------
`default_nettype none

module ccal_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire ccal_pkg::item_t                item,
    input  wire logic [ccal_pkg::TPS_W-1:0]     tps,
    output ccal_pkg::result_t                   res,
    output logic                                prescale_zero
);
    import ccal_pkg::*;

    cal_t             cal_reg;
    cal_t             cal_next;
    cal_t             cal_bump;
    logic [TPS_W-1:0] pre_reg;
    logic [TPS_W-1:0] pre_next;
    logic [TPS_W:0]   pre_inc;
    logic             elapsed;

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] mon_inc;
    logic [4:0] dim;

    // calendar after one more second
    always_comb
    begin
        sec_inc  = {1'b0, cal_reg.second} + 7'd1;
        min_inc  = {1'b0, cal_reg.minute} + 7'd1;
        hour_inc = {1'b0, cal_reg.hour} + 6'd1;
        day_inc  = {1'b0, cal_reg.day} + 6'd1;
        mon_inc  = {1'b0, cal_reg.month} + 5'd1;
        dim      = month_days(cal_reg.month, is_leap(cal_reg.year));
        cal_bump = cal_reg;
        if (sec_inc < SEC_PER_MIN)
            cal_bump.second = sec_inc[5:0];
        else
        begin
            cal_bump.second = 6'd0;
            if (min_inc < MIN_PER_HOUR)
                cal_bump.minute = min_inc[5:0];
            else
            begin
                cal_bump.minute = 6'd0;
                if (hour_inc < HOUR_PER_DAY)
                    cal_bump.hour = hour_inc[4:0];
                else
                begin
                    cal_bump.hour = 5'd0;
                    if (day_inc <= {1'b0, dim})
                        cal_bump.day = day_inc[4:0];
                    else
                    begin
                        cal_bump.day = 5'd1;
                        if (mon_inc <= MONTH_PER_YEAR)
                            cal_bump.month = mon_inc[3:0];
                        else
                        begin
                            cal_bump.month = 4'd1;
                            cal_bump.year  = cal_reg.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        cal_next = cal_reg;
        pre_next = pre_reg;
        elapsed  = 1'b0;
        pre_inc  = {1'b0, pre_reg} + 8'd1;
        case (item.mode)
            MODE_TICK:
            begin
                if (pre_inc >= {1'b0, tps})
                begin
                    pre_next = '0;
                    elapsed  = 1'b1;
                    cal_next = cal_bump;
                end
                else
                    pre_next = pre_inc[TPS_W-1:0];
            end
            MODE_SET_DATE:
            begin
                cal_next.year  = item.set_year;
                cal_next.month = item.set_month;
                cal_next.day   = item.set_day;
            end
            MODE_SET_TIME:
            begin
                cal_next.hour   = item.set_hour;
                cal_next.minute = item.set_minute;
                cal_next.second = item.set_second;
                pre_next        = '0;
            end
            default:
            begin
                // unused mode leaves everything as it is
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= CAL_RESET;
            pre_reg <= '0;
        end
        else if (adv)
        begin
            cal_reg <= cal_next;
            pre_reg <= pre_next;
        end
    end

    assign res.now            = cal_next;
    assign res.second_elapsed = elapsed;
    assign prescale_zero      = (pre_reg == '0);

endmodule

`default_nettype wire

@@ rtl/calendar_clock_tick.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_tick
// calendar clock with tick prescaler, set-date and set-time commands
// ----------------------------------------------------------------------------
// One beat in, one beat out. The block takes a new beat every cycle unless
// both registers are full and m_tready is low. An accepted beat is held in
// the input register; the calendar cascade then runs from it into the
// output register, which drives m_tvalid. While a result waits on m_tready,
// one more beat can still enter the input register. The user must write
// ticks_per_second through cfg_we/cfg_wdata only while no beat is in flight;
// the block does not enforce this. No clearing pass is needed after reset.
`default_nettype none

module calendar_clock_tick (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,   // ticks_per_second
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // set_year, set_month, set_day, set_hour, set_minute, set_second, zero pad
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,     // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // year_now, month_now, day_now, hour_now, minute_now, second_now, zero pad
    output logic [47:0]      m_tdata,
    output logic [0:0]       m_tuser      // second_elapsed
);
    import ccal_pkg::*;

    logic [TPS_W-1:0] tps_val_reg;
    logic             in_vld;
    item_t            in_item;
    logic             adv;
    result_t          res;
    logic             prescale_zero;
    logic             out_vld_reg;
    logic             out_vld_next;
    result_t          out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_val_reg <= TPS_RESET;
        else if (cfg_we)
            tps_val_reg <= cfg_wdata;
    end

    assign adv = in_vld && (!out_vld_reg || m_tready);

    ccal_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .item_vld (in_vld),
        .item     (in_item)
    );

    ccal_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .item          (in_item),
        .tps           (tps_val_reg),
        .res           (res),
        .prescale_zero (prescale_zero)
    );

    assign out_vld_next = adv || (out_vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.now.second, out_reg.now.minute,
                       out_reg.now.hour, out_reg.now.day, out_reg.now.month,
                       out_reg.now.year};
    assign m_tuser  = out_reg.second_elapsed;

`include "assert_macros.svh"

    // a second just completed leaves the prescaler at zero until the next beat
    `ASSERT_IMP(a_elapsed_clears_prescale, out_vld_reg && out_reg.second_elapsed,
        prescale_zero, "prescaler not cleared after a completed second")

    // a completed second never leaves an out-of-range second
    `ASSERT_IMP(a_elapsed_second_range, out_vld_reg && out_reg.second_elapsed,
        out_reg.now.second < 6'd60, "second out of range after carry")

    // back-pressure on the input only when both stages are full and stalled
    `ASSERT_IMP(a_stall_only_when_full, !s_tready,
        in_vld && out_vld_reg && !m_tready, "input stalled with room in the pipe")

    // a beat advancing out of the input register reaches the output register on the next edge
    `ASSERT_NXT(a_adv_fills_output, adv, out_vld_reg, "result lost after advance")

endmodule

`default_nettype wire
